// ===== hw/rtl/sves_pkg.sv =====
// Package for the supply voltage enable supervisor.
// Holds sizes, configuration layout, codes and state types shared by all RTL files.
// No dependencies.
`default_nettype none

package sves_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int BURST_SAMPLES = 16;

    localparam int SUM_W     = 14;
    localparam int CNT_W     = 5;
    localparam int TIME_W    = 32;
    localparam int CV_W      = 16;
    localparam int DELAY_W   = 20;
    localparam int FRAC_BITS = 6;
    localparam int HIST_W    = 22;
    localparam int ADC_FULL_CODE = 1023;

    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int TOTAL_W = HIST_W + FILL_W;

    // shared serial divider sizing
    localparam int DEN_W     = 16;
    localparam int DIV_NUM_W = SUM_W + CV_W + FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULLSCALE  = 3'd0,
        REG_TURN_ON    = 3'd1,
        REG_OFF_HIGH   = 3'd2,
        REG_OFF_LOW    = 3'd3,
        REG_ON_DELAY   = 3'd4,
        REG_LOW_DELAY  = 3'd5,
        REG_CRIT_DELAY = 3'd6
    } sves_reg_t;

    typedef enum logic [1:0] {
        TR_NONE    = 2'd0,
        TR_ENABLE  = 2'd1,
        TR_DISABLE = 2'd2
    } sves_trans_t;

    typedef enum logic [2:0] {
        AV_IDLE,
        AV_MUL,
        AV_DIV1_GO,
        AV_DIV1_WAIT,
        AV_DIV2_GO,
        AV_DIV2_WAIT,
        AV_DONE
    } sves_av_state_t;

    typedef struct packed {
        logic [CV_W-1:0]    fullscale_cv;
        logic [CV_W-1:0]    turn_on_cv;
        logic [CV_W-1:0]    off_high_cv;
        logic [CV_W-1:0]    off_low_cv;
        logic [DELAY_W-1:0] on_delay_ms;
        logic [DELAY_W-1:0] low_delay_ms;
        logic [DELAY_W-1:0] critical_delay_ms;
    } sves_cfg_t;

    localparam sves_cfg_t CFG_RESET = '{
        fullscale_cv:      16'd5000,
        turn_on_cv:        16'd2400,
        off_high_cv:       16'd2200,
        off_low_cv:        16'd2000,
        on_delay_ms:       20'd5000,
        low_delay_ms:      20'd5000,
        critical_delay_ms: 20'd500
    };

    // voltage handed from the averaging unit to the enable logic
    typedef struct packed {
        logic            valid;
        logic [CV_W-1:0] cv;
    } sves_volt_t;

    typedef struct packed {
        logic        is_enabled;
        sves_trans_t transition;
    } sves_gate_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sves_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on sves_pkg for operand widths.
`default_nettype none

module sves_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sves_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [sves_pkg::DEN_W-1:0]     den,
    output logic                                done,
    output logic [sves_pkg::DIV_NUM_W-1:0]      quot
);
    import sves_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where the numerator bits leave
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sves_avg.sv =====
// Averaging unit: history memory, running total and sequencer around the shared divider.
// Depends on sves_pkg and sves_div.
`default_nettype none

module sves_avg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [sves_pkg::SUM_W-1:0] adc_sum,
    input  wire logic [sves_pkg::CNT_W-1:0] sample_count,
    input  wire logic [sves_pkg::CV_W-1:0]  fullscale_cv,
    input  wire logic                     out_free,
    output logic                          idle,
    output sves_pkg::sves_volt_t          volt
);
    import sves_pkg::*;

    sves_av_state_t       state_reg, state_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [CV_W-1:0]      last_reg, last_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W+CV_W-1:0] prod_reg, prod_next;
    logic [DEN_W-1:0]     den_reg, den_next;

    logic [HIST_W-1:0]    mem [HISTORY_DEPTH];
    logic [HIST_W-1:0]    rdata_reg;
    logic                 rd_en, wr_en;
    logic [HIST_W-1:0]    inst;
    logic [HIST_W-1:0]    old_entry;
    logic [TOTAL_W:0]     rounded;

    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DEN_W-1:0]     div_den;
    logic                 count_ok;

    sves_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign count_ok = (sample_count != '0) && (32'(sample_count) <= BURST_SAMPLES);

    // instant voltage saturates at the entry width
    assign inst = (|div_quot[DIV_NUM_W-1:HIST_W]) ? '1 : div_quot[HIST_W-1:0];
    // slot being replaced holds nothing until the ring has been filled once
    assign old_entry = (fill_reg == FILL_W'(HISTORY_DEPTH)) ? rdata_reg : '0;
    assign rounded = (TOTAL_W+1)'(total_reg)
                   + ((TOTAL_W+1)'(fill_reg) << (FRAC_BITS - 1));

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        div_num    = DIV_NUM_W'({prod_reg, FRAC_BITS'(0)}) + DIV_NUM_W'(den_reg >> 1);
        div_den    = den_reg;
        volt.valid = 1'b0;
        volt.cv    = last_reg;
        case (state_reg)
            AV_IDLE:
            begin
                if (start)
                begin
                    sum_next = adc_sum;
                    cnt_next = sample_count;
                    rd_en    = 1'b1;
                    state_next = count_ok ? AV_MUL : AV_DONE;
                end
            end
            AV_MUL:
            begin
                prod_next  = (SUM_W+CV_W)'(sum_reg) * (SUM_W+CV_W)'(fullscale_cv);
                den_next   = DEN_W'(cnt_reg) * DEN_W'(ADC_FULL_CODE);
                state_next = AV_DIV1_GO;
            end
            AV_DIV1_GO:
            begin
                div_start  = 1'b1;
                state_next = AV_DIV1_WAIT;
            end
            AV_DIV1_WAIT:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    total_next = total_reg - TOTAL_W'(old_entry) + TOTAL_W'(inst);
                    slot_next  = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                               : slot_reg + 1'b1;
                    if (fill_reg != FILL_W'(HISTORY_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = AV_DIV2_GO;
                end
            end
            AV_DIV2_GO:
            begin
                // floor(floor((t + 32f) / 64) / f) rounds t / (64 f) half up
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'(rounded >> FRAC_BITS);
                div_den    = DEN_W'(fill_reg);
                state_next = AV_DIV2_WAIT;
            end
            AV_DIV2_WAIT:
            begin
                if (div_done)
                begin
                    last_next  = (|div_quot[DIV_NUM_W-1:CV_W]) ? '1 : div_quot[CV_W-1:0];
                    state_next = AV_DONE;
                end
            end
            AV_DONE:
            begin
                if (out_free)
                begin
                    volt.valid = 1'b1;
                    state_next = AV_IDLE;
                end
            end
            default:
            begin
                state_next = AV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AV_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_reg] <= inst;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[slot_reg];
        end
    end

    assign idle = (state_reg == AV_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/sves_gate.sv =====
// Enable decision: hysteresis thresholds, delay timer and forced disable.
// Depends on sves_pkg.
`default_nettype none

module sves_gate (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sves_pkg::sves_cfg_t         cfg,
    input  wire sves_pkg::sves_volt_t        volt,
    input  wire logic                        button_on,
    input  wire logic [sves_pkg::TIME_W-1:0] time_ms,
    output sves_pkg::sves_gate_t             result
);
    import sves_pkg::*;

    logic              en_reg, en_next;
    logic [TIME_W-1:0] timer_reg, timer_next;
    logic [TIME_W-1:0] elapsed;

    assign elapsed = time_ms - timer_reg;

    always_comb
    begin
        en_next    = en_reg;
        timer_next = timer_reg;
        if (!button_on)
        begin
            en_next = 1'b0;
        end
        else if (!en_reg)
        begin
            if (volt.cv >= cfg.turn_on_cv)
            begin
                // zero timer means not timing
                if (timer_reg == '0)
                begin
                    timer_next = time_ms;
                end
                else if (elapsed >= TIME_W'(cfg.on_delay_ms))
                begin
                    en_next = 1'b1;
                end
            end
            else
            begin
                timer_next = '0;
            end
        end
        else
        begin
            if (volt.cv <= cfg.off_low_cv)
            begin
                if (elapsed >= TIME_W'(cfg.critical_delay_ms))
                begin
                    en_next = 1'b0;
                end
            end
            else if (volt.cv <= cfg.off_high_cv)
            begin
                if (elapsed >= TIME_W'(cfg.low_delay_ms))
                begin
                    en_next = 1'b0;
                end
            end
            else
            begin
                timer_next = time_ms;
            end
        end

        result.is_enabled = en_next;
        if (en_next == en_reg)
        begin
            result.transition = TR_NONE;
        end
        else if (en_next)
        begin
            result.transition = TR_ENABLE;
        end
        else
        begin
            result.transition = TR_DISABLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            timer_reg <= '0;
        end
        else if (volt.valid)
        begin
            en_reg    <= en_next;
            timer_reg <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/supply_voltage_enable_supervisor.sv =====
// Top level of the supply voltage enable supervisor: ports, configuration registers,
// input capture and output register. Depends on sves_pkg, sves_avg and sves_gate.
//
//  Channel   Direction  Handshake                Content
//  s_axis    in         s_axis_tvalid/tready     check event (burst, button, time)
//  m_axis    out        m_axis_tvalid/tready     enable state, average, transition
//  cfg       in         cfg_valid/cfg_ready      register index and write data
//
// An event with 1..16 samples runs through the bit-serial divider (37 steps), once for
// the instant voltage and once for the mean. An event with no usable samples skips the
// multiply and both divisions. One event is in work at a time; the next is taken once
// the current result sits in the output register.
// A stalled output holds the finished result; the unit waits until the register frees.
// Reset clears the fill count, the timer and the enable state; entries not yet written
// are ignored through the fill count, so there is no clearing pass.
`default_nettype none

module supply_voltage_enable_supervisor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [13:0] adc_sum, [18:14] sample_count, [19] button_on, [51:20] time_ms
    input  wire logic [sves_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] is_enabled, [16:1] average_cv, [18:17] transition
    output logic [sves_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sves_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sves_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sves_pkg::*;

    sves_cfg_t          cfg_reg;
    logic               s_acc;
    logic               avg_idle;
    logic               out_free;
    sves_volt_t         volt;
    sves_gate_t         gate;
    logic               btn_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = avg_idle;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sves_reg_t'(cfg_index))
                REG_FULLSCALE:  cfg_reg.fullscale_cv      <= cfg_data[CV_W-1:0];
                REG_TURN_ON:    cfg_reg.turn_on_cv        <= cfg_data[CV_W-1:0];
                REG_OFF_HIGH:   cfg_reg.off_high_cv       <= cfg_data[CV_W-1:0];
                REG_OFF_LOW:    cfg_reg.off_low_cv        <= cfg_data[CV_W-1:0];
                REG_ON_DELAY:   cfg_reg.on_delay_ms       <= cfg_data[DELAY_W-1:0];
                REG_LOW_DELAY:  cfg_reg.low_delay_ms      <= cfg_data[DELAY_W-1:0];
                REG_CRIT_DELAY: cfg_reg.critical_delay_ms <= cfg_data[DELAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            btn_reg  <= s_axis_tdata[SUM_W+CNT_W];
            time_reg <= s_axis_tdata[SUM_W+CNT_W+1 +: TIME_W];
        end
    end

    sves_avg u_avg (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (s_acc),
        .adc_sum      (s_axis_tdata[SUM_W-1:0]),
        .sample_count (s_axis_tdata[SUM_W +: CNT_W]),
        .fullscale_cv (cfg_reg.fullscale_cv),
        .out_free     (out_free),
        .idle         (avg_idle),
        .volt         (volt)
    );

    sves_gate u_gate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .volt      (volt),
        .button_on (btn_reg),
        .time_ms   (time_reg),
        .result    (gate)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (volt.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (volt.valid)
        begin
            out_data_reg <= OUT_DATA_W'({gate.transition, volt.cv, gate.is_enabled});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a finished voltage never overwrites a result still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        volt.valid |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwritten before transfer");

    // one event in work at a time
    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_axis_tready)
        else $error("second event accepted while busy");

    // an enable transition always reports the enabled state
    a_enable_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[18:17] == TR_ENABLE) |-> m_axis_tdata[0])
        else $error("enable transition without enabled state");

    // results appear only after an accepted event
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!avg_idle))
        else $error("result without event in work");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for supply_voltage_enable_supervisor: check events are streamed in,
// each result is compared against an in-bench model of the averaging and enable logic.
// Depends on sves_pkg and the supervisor RTL.
`timescale 1ns / 1ps

module tb_top;
    import sves_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 100;
    localparam logic [63:0] HIST_MAX = (64'd1 << HIST_W) - 64'd1;

    typedef struct {
        logic [SUM_W-1:0]  adc_sum;
        logic [CNT_W-1:0]  sample_count;
        logic              button_on;
        logic [TIME_W-1:0] time_ms;
    } check_event_t;

    typedef struct {
        logic            is_enabled;
        logic [CV_W-1:0] average_cv;
        sves_trans_t     transition;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // model copy of the configuration
    logic [CV_W-1:0]    fs_cv      = CFG_RESET.fullscale_cv;
    logic [CV_W-1:0]    on_cv      = CFG_RESET.turn_on_cv;
    logic [CV_W-1:0]    low_cv     = CFG_RESET.off_high_cv;
    logic [CV_W-1:0]    crit_cv    = CFG_RESET.off_low_cv;
    logic [DELAY_W-1:0] on_delay   = CFG_RESET.on_delay_ms;
    logic [DELAY_W-1:0] low_delay  = CFG_RESET.low_delay_ms;
    logic [DELAY_W-1:0] crit_delay = CFG_RESET.critical_delay_ms;

    // model copy of the supervisor state
    logic [HIST_W-1:0] ring [HISTORY_DEPTH];
    int                ring_slot = 0;
    int                ring_fill = 0;
    logic [CV_W-1:0]   mean_cv = '0;
    logic              on_flag = 1'b0;
    logic [TIME_W-1:0] timer_mark = '0;

    check_event_t events_queued[$];
    verdict_t     verdicts_due[$];
    verdict_t     want;

    // stimulus shaping
    int                lvl_code = 0;
    int                seg_left = 0;
    int                step_hi = 1000;
    logic [TIME_W-1:0] now_ms = '0;
    logic              gaps_on = 1'b0;
    logic              stalls_on = 1'b0;
    int                hold_requests = 0;
    int                holds_served = 0;
    int                hold_left = 0;
    int                gap_left = 0;
    logic              taken = 1'b0;
    int                errors = 0;
    int                quiet = 0;

    supply_voltage_enable_supervisor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
            ring[i] = '0;
    end

    task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
        errors++;
        if (errors <= 100)
            $display("mismatch %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
    endtask

    // Burst to rolling mean in centivolts; a burst without usable samples reuses the mean.
    function automatic logic [CV_W-1:0] track_average(logic [SUM_W-1:0] sum,
                                                      logic [CNT_W-1:0] count);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] inst;
        logic [63:0] total;
        logic [63:0] wide_sum;
        logic [63:0] wide_fs;
        logic [63:0] wide_cnt;
        if (count == 0 || count > BURST_SAMPLES)
            return mean_cv;
        wide_sum = 64'(sum);
        wide_fs  = 64'(fs_cv);
        wide_cnt = 64'(count);
        num  = (wide_sum * wide_fs) << FRAC_BITS;
        den  = wide_cnt * ADC_FULL_CODE;
        inst = (num + den / 2) / den;
        if (inst > HIST_MAX)
            inst = HIST_MAX;
        ring[ring_slot] = inst[HIST_W-1:0];
        ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
        if (ring_fill < HISTORY_DEPTH)
            ring_fill++;
        total = 0;
        for (int i = 0; i < ring_fill; i++)
            total += ring[i];
        den = 64'(ring_fill);
        den = den << FRAC_BITS;
        total = (total + den / 2) / den;
        mean_cv = (total > 64'd65535) ? 16'hFFFF : total[CV_W-1:0];
        return mean_cv;
    endfunction

    function automatic verdict_t supervise_event(check_event_t ev);
        logic              was_on;
        logic [CV_W-1:0]   v;
        logic [TIME_W-1:0] elapsed;
        verdict_t          res;
        was_on = on_flag;
        v = track_average(ev.adc_sum, ev.sample_count);
        if (!ev.button_on)
            on_flag = 1'b0;
        else if (!on_flag)
        begin
            if (v >= on_cv)
            begin
                // zero timestamp doubles as "not timing"
                if (timer_mark == 0)
                    timer_mark = ev.time_ms;
                else if (ev.time_ms - timer_mark >= on_delay)
                    on_flag = 1'b1;
            end
            else
                timer_mark = '0;
        end
        else
        begin
            elapsed = ev.time_ms - timer_mark;
            if (v <= crit_cv)
            begin
                if (elapsed >= crit_delay)
                    on_flag = 1'b0;
            end
            else if (v <= low_cv)
            begin
                if (elapsed >= low_delay)
                    on_flag = 1'b0;
            end
            else
                timer_mark = ev.time_ms;
        end
        res.is_enabled = on_flag;
        res.average_cv = v;
        if (was_on == on_flag)
            res.transition = TR_NONE;
        else if (on_flag)
            res.transition = TR_ENABLE;
        else
            res.transition = TR_DISABLE;
        return res;
    endfunction

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int code_of(int cv);
        int c;
        if (fs_cv == 0)
            return $urandom_range(0, 1023);
        c = cv * 1023 / int'(fs_cv);
        return (c > 1023) ? 1023 : c;
    endfunction

    function automatic check_event_t make_event();
        check_event_t ev;
        int           r;
        int           b;
        int           s;
        int           acc;
        if (seg_left == 0)
        begin
            b = $urandom_range(0, 5);
            case (b)
                0: lvl_code = code_of(on_cv) + $urandom_range(0, 20);
                1: lvl_code = $urandom_range(code_of(low_cv), code_of(on_cv));
                2: lvl_code = $urandom_range(code_of(crit_cv), code_of(low_cv));
                3: lvl_code = code_of(crit_cv) - int'($urandom_range(0, 30));
                4: lvl_code = $urandom_range(0, 1023);
                default: lvl_code = 1023;
            endcase
            if (lvl_code < 0)
                lvl_code = 0;
            if (lvl_code > 1023)
                lvl_code = 1023;
            seg_left = $urandom_range(3, 30);
        end
        seg_left--;
        if ($urandom_range(0, 99) < 2)
            now_ms += $urandom;
        else
            now_ms += $urandom_range(0, step_hi);
        ev.time_ms = now_ms;
        ev.button_on = ($urandom_range(0, 99) >= 4);
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            ev.sample_count = CNT_W'($urandom_range(1, BURST_SAMPLES));
            acc = 0;
            for (int i = 0; i < ev.sample_count; i++)
            begin
                s = lvl_code + int'($urandom_range(0, 6)) - 3;
                if (s < 0)
                    s = 0;
                if (s > 1023)
                    s = 1023;
                acc += s;
            end
            ev.adc_sum = SUM_W'(acc);
        end
        else if (r < 88)
        begin
            ev.sample_count = '0;
            ev.adc_sum = SUM_W'($urandom_range(0, 16383));
        end
        else if (r < 93)
        begin
            ev.sample_count = CNT_W'($urandom_range(BURST_SAMPLES + 1, 31));
            ev.adc_sum = SUM_W'($urandom_range(0, 16383));
        end
        else
        begin
            ev.sample_count = CNT_W'($urandom_range(1, BURST_SAMPLES));
            ev.adc_sum = SUM_W'($urandom_range(0, 16383));
        end
        return ev;
    endfunction

    task automatic queue_check(int sum, int count, logic button, logic [TIME_W-1:0] t);
        check_event_t ev;
        ev.adc_sum = SUM_W'(sum);
        ev.sample_count = CNT_W'(count);
        ev.button_on = button;
        ev.time_ms = t;
        events_queued.push_back(ev);
    endtask

    task automatic drain();
        while (events_queued.size() != 0 || verdicts_due.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    task automatic write_reg(sves_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FULLSCALE:  fs_cv      = value[CV_W-1:0];
            REG_TURN_ON:    on_cv      = value[CV_W-1:0];
            REG_OFF_HIGH:   low_cv     = value[CV_W-1:0];
            REG_OFF_LOW:    crit_cv    = value[CV_W-1:0];
            REG_ON_DELAY:   on_delay   = value;
            REG_LOW_DELAY:  low_delay  = value;
            REG_CRIT_DELAY: crit_delay = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // 16-bit registers get junk in the unused top bits of the write data
    task automatic write_all(int fs, int on, int hi, int lo, int d_on, int d_low, int d_crit);
        write_reg(REG_FULLSCALE,  {4'($urandom), 16'(fs)});
        write_reg(REG_TURN_ON,    {4'($urandom), 16'(on)});
        write_reg(REG_OFF_HIGH,   {4'($urandom), 16'(hi)});
        write_reg(REG_OFF_LOW,    {4'($urandom), 16'(lo)});
        write_reg(REG_ON_DELAY,   20'(d_on));
        write_reg(REG_LOW_DELAY,  20'(d_low));
        write_reg(REG_CRIT_DELAY, 20'(d_crit));
    endtask

    task automatic feed(int n);
        for (int i = 0; i < n; i++)
            events_queued.push_back(make_event());
    endtask

    // input side: transaction bookkeeping at the rising edge
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            verdicts_due.push_back(supervise_event(events_queued.pop_front()));
            gap_left = gaps_on ? pick_gap() : 0;
            taken = 1'b1;
        end
    end

    // input side: drive at the falling edge, valid held until the transaction completes
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || taken)
        begin
            taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (events_queued.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, events_queued[0].time_ms, events_queued[0].button_on,
                                  events_queued[0].sample_count, events_queued[0].adc_sum};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output side back-pressure
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        else if (hold_left == 0 && stalls_on && $urandom_range(0, 9) == 0)
            hold_left = pick_gap();
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // output monitor
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("unexpected result", 64'd0, 64'(m_axis_tdata));
            else
            begin
                want = verdicts_due.pop_front();
                if (m_axis_tdata[0] !== want.is_enabled)
                    report_mismatch("is_enabled", 64'(want.is_enabled), 64'(m_axis_tdata[0]));
                if (m_axis_tdata[16:1] !== want.average_cv)
                    report_mismatch("average_cv", 64'(want.average_cv),
                                    64'(m_axis_tdata[16:1]));
                if (m_axis_tdata[18:17] !== want.transition)
                    report_mismatch("transition", 64'(want.transition),
                                    64'(m_axis_tdata[18:17]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int fs;
        int on;
        int hi;
        int lo;
        int dmax;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset defaults, 2500 cV is about code 512, 2100 cV about 430
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        queue_check(0, 0, 1'b1, 0);                 // no samples right after reset
        queue_check(16383, 1, 1'b1, 0);             // saturating burst, timer started at zero
        queue_check(16368, 16, 1'b1, 0);
        queue_check(16368, 17, 1'b1, 50);           // oversized burst
        queue_check(9999, 31, 1'b1, 60);
        queue_check(8192, 16, 1'b1, 1000);
        queue_check(8192, 16, 1'b1, 3000);
        queue_check(8192, 16, 1'b1, 6000);
        queue_check(8192, 16, 1'b1, 7000);
        for (int i = 0; i < 6; i++)
            queue_check(6880, 16, 1'b1, 7100 + i * 100);
        queue_check(6880, 16, 1'b1, 13000);
        queue_check(5600, 16, 1'b1, 13100);         // critical band
        queue_check(5600, 16, 1'b1, 13700);
        queue_check(0, 16, 1'b1, 14000);
        queue_check(8192, 16, 1'b0, 14100);         // button off
        queue_check(16368, 16, 1'b1, 32'hFFFF_FF00);
        queue_check(16368, 16, 1'b1, 32'hFFFF_FFFF);
        queue_check(16368, 16, 1'b1, 32'h0000_1500); // timestamp wrap
        queue_check(16368, 16, 1'b0, 32'h0000_1600);
        drain();

        // defaults, with a long output hold-off so the input backs up
        now_ms = 32'd20000;
        step_hi = 1500;
        feed(200);
        hold_requests++;
        drain();

        // no idling on either side
        write_all(5000, 2400, 2200, 2000, $urandom_range(0, 400), $urandom_range(0, 400),
                  $urandom_range(0, 400));
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        step_hi = 150;
        feed(200);
        drain();

        // all registers at zero
        write_all(0, 0, 0, 0, 0, 0, 0);
        gaps_on = 1'b1;
        step_hi = 3;
        feed(100);
        drain();

        // all registers at full scale, starting just below the timestamp wrap
        write_all(65535, 65535, 65535, 65535, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        now_ms = 32'hFFFF_0000;
        step_hi = 200000;
        feed(100);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                fs = $urandom_range(0, 65535);
                on = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
                lo = $urandom_range(0, 65535);
            end
            else
            begin
                fs = $urandom_range(1000, 20000);
                on = $urandom_range(fs / 4, fs);
                hi = on - int'($urandom_range(0, 400));
                lo = hi - int'($urandom_range(0, 400));
                if (hi < 0)
                    hi = 0;
                if (lo < 0)
                    lo = 0;
            end
            dmax = 1 << $urandom_range(4, 12);
            write_all(fs, on, hi, lo, $urandom_range(0, dmax), $urandom_range(0, dmax),
                      $urandom_range(0, dmax));
            gaps_on = 1'($urandom_range(0, 1));
            stalls_on = 1'($urandom_range(0, 1));
            step_hi = dmax / 4 + 1;
            feed(165);
            if (p == 2)
                hold_requests++;
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sves_pkg.sv
hw/rtl/sves_div.sv
hw/rtl/sves_avg.sv
hw/rtl/sves_gate.sv
hw/rtl/supply_voltage_enable_supervisor.sv
test/tb_top.sv
